// File: sv/floppy_drive_control_status_regs_unit_macros.svh
// assertion macros used by the checker file
`ifndef FLOPPY_DRIVE_CONTROL_STATUS_REGS_UNIT_MACROS_SVH
`define FLOPPY_DRIVE_CONTROL_STATUS_REGS_UNIT_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define FDCS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("fdcs same-cycle check failed");

// next-cycle implication, disabled while reset is low
`define FDCS_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("fdcs next-cycle check failed");

`endif

// File: sv/fdcs_pkg.sv
// shared types and codes for the floppy drive control and status registers
`default_nettype none

package fdcs_pkg;

  // bus commands
  typedef enum logic [1:0] {
    CMD_PHASE  = 2'd0,
    CMD_ENABLE = 2'd1,
    CMD_SELECT = 2'd2,
    CMD_STATUS = 2'd3
  } cmd_e;

  // phase line bits
  localparam logic [3:0] LINE_CA0  = 4'h1;
  localparam logic [3:0] LINE_CA1  = 4'h2;
  localparam logic [3:0] LINE_CA2  = 4'h4;
  localparam logic [3:0] LINE_STRB = 4'h8;
  localparam logic [3:0] LINE_MASK = 4'hF;

  // enable mask values
  localparam logic [3:0] ENABLE_DRIVE0 = 4'h1;
  localparam logic [3:0] ENABLE_DRIVE1 = 4'h2;

  // strobe command addresses
  localparam logic [3:0] ADDR_DIR_INWARD  = 4'h0;
  localparam logic [3:0] ADDR_DIR_OUTWARD = 4'h1;
  localparam logic [3:0] ADDR_CLR_SWITCH  = 4'h3;
  localparam logic [3:0] ADDR_STEP        = 4'h4;
  localparam logic [3:0] ADDR_MOTOR_ON    = 4'h8;
  localparam logic [3:0] ADDR_MOTOR_OFF   = 4'h9;
  localparam logic [3:0] ADDR_EJECT       = 4'hD;

  // status sense addresses
  localparam logic [3:0] STS_DIR        = 4'h0;
  localparam logic [3:0] STS_HEAD_LOWER = 4'h1;
  localparam logic [3:0] STS_NO_DISK    = 4'h2;
  localparam logic [3:0] STS_HEAD_UPPER = 4'h3;
  localparam logic [3:0] STS_STEP_IDLE  = 4'h4;
  localparam logic [3:0] STS_DENSITY    = 4'h5;
  localparam logic [3:0] STS_LOCK       = 4'h6;
  localparam logic [3:0] STS_MOTOR      = 4'h8;
  localparam logic [3:0] STS_SIDES      = 4'h9;
  localparam logic [3:0] STS_TRACK0     = 4'hA;
  localparam logic [3:0] STS_READY      = 4'hB;
  localparam logic [3:0] STS_SWITCHED   = 4'hC;
  localparam logic [3:0] STS_INSTALLED  = 4'hD;
  localparam logic [3:0] STS_TACH       = 4'hE;
  localparam logic [3:0] STS_DENSITY_HI = 4'hF;

  // step request codes
  localparam logic [1:0] STEP_NONE   = 2'd0;
  localparam logic [1:0] STEP_HIGHER = 2'd1;
  localparam logic [1:0] STEP_LOWER  = 2'd2;

  // one bus access with its mechanism sense levels
  typedef struct packed {
    cmd_e       cmd;
    logic [3:0] value;
    logic       disk_present;
    logic       write_protect_level;
    logic       track0_level;
    logic       disk_change_level;
    logic       two_sided;
    logic       tach_level;
  } in_item_t;

  // one result beat
  typedef struct packed {
    logic       status_bit;
    logic [1:0] step_request;
    logic       motor_write;
    logic       motor_level;
    logic       eject_request;
    logic       flush_track;
    logic       head_select;
    logic       active_drive;
  } result_t;

endpackage

`default_nettype wire

// File: sv/fdcs_exec.sv
// drive state registers and the decode of one bus access
`default_nettype none

module fdcs_exec (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              fire_i,
  input  wire fdcs_pkg::in_item_t item_i,
  input  wire logic              cfg_we_i,
  input  wire logic [1:0]        cfg_hd_i,
  output fdcs_pkg::result_t      result_o
);
  import fdcs_pkg::*;

  logic [1:0] hd_q;
  logic [3:0] phase_q, phase_d;
  logic       enabled_q, enabled_d;
  logic       chosen_q, chosen_d;
  logic       sel_q, sel_d;
  logic [1:0] outward_q, outward_d;
  logic [1:0] head_q, head_d;
  logic [1:0] motor_off_q, motor_off_d;
  logic [1:0] switched_q, switched_d;
  logic [1:0] single_q, single_d;

  logic       d;
  logic       strobe_rise;
  logic       blocked;
  logic [3:0] cmd_addr;
  logic [3:0] sts_addr;
  logic       present;

  assign d        = chosen_q;
  assign present  = item_i.disk_present;
  assign cmd_addr = {item_i.value[1], item_i.value[0], sel_q, item_i.value[2]};
  assign sts_addr = {phase_q[1], phase_q[0], sel_q, phase_q[2]};
  assign strobe_rise = |(item_i.value & LINE_STRB & ~phase_q);
  assign blocked  = (|(phase_q & LINE_CA1)) && (|(phase_q & LINE_STRB));

  // next state and result of the access
  always_comb begin
    phase_d     = phase_q;
    enabled_d   = enabled_q;
    chosen_d    = chosen_q;
    sel_d       = sel_q;
    outward_d   = outward_q;
    head_d      = head_q;
    motor_off_d = motor_off_q;
    switched_d  = switched_q;
    single_d    = single_q;

    result_o               = '0;
    result_o.status_bit    = 1'b1;
    result_o.step_request  = STEP_NONE;

    case (item_i.cmd)
      CMD_PHASE: begin
        phase_d = item_i.value & LINE_MASK;
        if (strobe_rise && enabled_q) begin
          case (cmd_addr)
            ADDR_DIR_INWARD:  outward_d[d] = 1'b0;
            ADDR_DIR_OUTWARD: outward_d[d] = 1'b1;
            ADDR_CLR_SWITCH:  switched_d[d] = 1'b0;
            ADDR_STEP: begin
              if (present) begin
                result_o.flush_track  = 1'b1;
                result_o.step_request = outward_q[d] ? STEP_LOWER : STEP_HIGHER;
              end
            end
            ADDR_MOTOR_ON: begin
              motor_off_d[d]       = 1'b0;
              result_o.motor_write = present;
            end
            ADDR_MOTOR_OFF: begin
              motor_off_d[d]       = 1'b1;
              result_o.motor_write = present;
            end
            ADDR_EJECT: begin
              if (present) begin
                result_o.eject_request = 1'b1;
                result_o.flush_track   = 1'b1;
                outward_d[d]   = 1'b0;
                head_d[d]      = 1'b0;
                motor_off_d[d] = 1'b0;
                switched_d[d]  = 1'b0;
                single_d[d]    = 1'b0;
              end
            end
            default: ;
          endcase
        end
      end
      CMD_ENABLE: begin
        if (item_i.value == ENABLE_DRIVE0) begin
          enabled_d = 1'b1;
          chosen_d  = 1'b0;
        end else if (item_i.value == ENABLE_DRIVE1) begin
          enabled_d = 1'b1;
          chosen_d  = 1'b1;
        end else begin
          enabled_d = 1'b0;
        end
      end
      CMD_SELECT: sel_d = |item_i.value;
      CMD_STATUS: begin
        if (!blocked && enabled_q) begin
          case (sts_addr)
            STS_DIR:        result_o.status_bit = outward_q[d];
            STS_HEAD_LOWER: begin
              if (head_q[d]) begin
                result_o.flush_track = 1'b1;
                head_d[d] = 1'b0;
              end
              result_o.status_bit = 1'b0;
            end
            STS_NO_DISK:    result_o.status_bit = !present;
            STS_HEAD_UPPER: begin
              if (!head_q[d] && !single_q[d]) begin
                result_o.flush_track = 1'b1;
                head_d[d] = 1'b1;
              end
              result_o.status_bit = 1'b0;
            end
            STS_STEP_IDLE:  result_o.status_bit = 1'b1;
            STS_DENSITY:    result_o.status_bit = hd_q[d];
            STS_LOCK:       result_o.status_bit = present & item_i.write_protect_level;
            STS_MOTOR:      result_o.status_bit = motor_off_q[d];
            STS_SIDES: begin
              if (present) begin
                result_o.status_bit = item_i.two_sided;
                single_d[d] = !item_i.two_sided;
              end
            end
            STS_TRACK0:     result_o.status_bit = present & item_i.track0_level;
            STS_READY:      result_o.status_bit = 1'b0;
            STS_SWITCHED: begin
              if (present && !item_i.disk_change_level) begin
                switched_d[d]       = 1'b1;
                result_o.status_bit = 1'b1;
              end else begin
                result_o.status_bit = switched_q[d];
              end
            end
            STS_INSTALLED:  result_o.status_bit = 1'b0;
            STS_TACH:       result_o.status_bit = !present | item_i.tach_level;
            STS_DENSITY_HI: result_o.status_bit = hd_q[d];
            default:        result_o.status_bit = 1'b1;
          endcase
        end
      end
      default: ;
    endcase

    // reported drive fields reflect the state after this access
    result_o.active_drive = chosen_d;
    result_o.motor_level  = motor_off_d[chosen_d];
    result_o.head_select  = head_d[chosen_d];
  end

  // state registers, updated when the access moves to the result stage; the density register on a configuration write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hd_q        <= '0;
      phase_q     <= '0;
      enabled_q   <= 1'b0;
      chosen_q    <= 1'b0;
      sel_q       <= 1'b0;
      outward_q   <= '0;
      head_q      <= '0;
      motor_off_q <= '0;
      switched_q  <= '0;
      single_q    <= '0;
    end else begin
      if (cfg_we_i) begin
        hd_q <= cfg_hd_i;
      end
      if (fire_i) begin
        phase_q     <= phase_d;
        enabled_q   <= enabled_d;
        chosen_q    <= chosen_d;
        sel_q       <= sel_d;
        outward_q   <= outward_d;
        head_q      <= head_d;
        motor_off_q <= motor_off_d;
        switched_q  <= switched_d;
        single_q    <= single_d;
      end
    end
  end

endmodule

`default_nettype wire

// File: sv/floppy_drive_control_status_regs_unit.sv
// top level: input register, access decode with drive state, result register
//
//   channel | direction | handshake              | payload
//   --------+-----------+------------------------+------------------------------
//   in      | to unit   | in_valid_i/in_ready_o  | cmd, value, mechanism levels
//   out     | from unit | out_valid_o/out_ready_i| status, requests, drive state
//   cfg     | to unit   | cfg_valid_i/cfg_ready_o| drive_is_high_density
//
// one beat per cycle sustained while the result channel is not stalled; each
// access waits in the input register and is decoded while it moves into
// the result register, which sets result valid.
// reset clears all drive state, the density register and both valid flags.
// a stalled result holds the result register; the input register still
// takes a beat while empty, so one beat can wait on each side.
`default_nettype none

module floppy_drive_control_status_regs_unit (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  // access channel
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [1:0] cmd_i,
  input  wire logic [3:0] value_i,
  input  wire logic       disk_present_i,
  input  wire logic       write_protect_level_i,
  input  wire logic       track0_level_i,
  input  wire logic       disk_change_level_i,
  input  wire logic       two_sided_i,
  input  wire logic       tach_level_i,
  // result channel
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic            status_bit_o,
  output logic [1:0]      step_request_o,
  output logic            motor_write_o,
  output logic            motor_level_o,
  output logic            eject_request_o,
  output logic            flush_track_o,
  output logic            head_select_o,
  output logic            active_drive_o,
  // configuration channel
  input  wire logic       cfg_valid_i,
  output logic            cfg_ready_o,
  input  wire logic [1:0] drive_is_high_density_i
);
  import fdcs_pkg::*;

  logic      in_vld_q;
  in_item_t  in_q;
  logic      out_vld_q;
  result_t   out_q;
  result_t   result;
  logic      fire;
  logic      in_take;

  // handshake control
  assign fire       = in_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o = !in_vld_q || fire;
  assign in_take    = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;

  // input register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  // input register payload
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_q.cmd                 <= cmd_e'(cmd_i);
      in_q.value               <= value_i;
      in_q.disk_present        <= disk_present_i;
      in_q.write_protect_level <= write_protect_level_i;
      in_q.track0_level        <= track0_level_i;
      in_q.disk_change_level   <= disk_change_level_i;
      in_q.two_sided           <= two_sided_i;
      in_q.tach_level          <= tach_level_i;
    end
  end

  // decode and drive state
  fdcs_exec u_exec (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fire_i   (fire),
    .item_i   (in_q),
    .cfg_we_i (cfg_valid_i && cfg_ready_o),
    .cfg_hd_i (drive_is_high_density_i),
    .result_o (result)
  );

  // result register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (fire) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  // result register payload
  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_q <= result;
    end
  end

  assign out_valid_o     = out_vld_q;
  assign status_bit_o    = out_q.status_bit;
  assign step_request_o  = out_q.step_request;
  assign motor_write_o   = out_q.motor_write;
  assign motor_level_o   = out_q.motor_level;
  assign eject_request_o = out_q.eject_request;
  assign flush_track_o   = out_q.flush_track;
  assign head_select_o   = out_q.head_select;
  assign active_drive_o  = out_q.active_drive;

endmodule

`default_nettype wire

// File: sv/fdcs_checker.sv
// port-level checks for the drive register unit and their bind
`default_nettype none
`include "floppy_drive_control_status_regs_unit_macros.svh"

module fdcs_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       in_ready_o,
  input wire logic       out_valid_o,
  input wire logic       out_ready_i,
  input wire logic       status_bit_o,
  input wire logic [1:0] step_request_o,
  input wire logic       motor_write_o,
  input wire logic       motor_level_o,
  input wire logic       eject_request_o,
  input wire logic       flush_track_o,
  input wire logic       head_select_o
);
  import fdcs_pkg::*;

  logic out_stall;
  logic eject_seen;
  logic eject_clean;
  logic step_seen;
  logic step_clean;

  // terms shared by the checks
  assign out_stall   = out_valid_o && !out_ready_i;
  assign eject_seen  = out_valid_o && eject_request_o;
  assign eject_clean = flush_track_o && (step_request_o == STEP_NONE) && !motor_write_o &&
                       status_bit_o && !head_select_o && !motor_level_o;
  assign step_seen   = out_valid_o && (step_request_o != STEP_NONE);
  assign step_clean  = flush_track_o && !eject_request_o && !motor_write_o;

  // a stalled result beat stays valid and its step request unchanged
  `FDCS_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_stall, out_valid_o && $stable(step_request_o))

  // an empty result stage never back-pressures the access channel
  `FDCS_ASSERT_IMP(a_room_ready, clk_i, rst_ni, !out_valid_o, in_ready_o)

  // eject comes with a flush, no step, no motor write, a high status bit, head select low and motor level low
  `FDCS_ASSERT_IMP(a_eject_flush, clk_i, rst_ni, eject_seen, eject_clean)

  // a step request flushes and excludes the other requests
  `FDCS_ASSERT_IMP(a_step_flush, clk_i, rst_ni, step_seen, step_clean)

endmodule

bind floppy_drive_control_status_regs_unit fdcs_checker u_fdcs_checker (.*);

`default_nettype wire
